### src/swmd_pkg.sv
// Shared types, constants and helpers for the sliding-window distinct counter.
// No dependencies; every other file of the block but swmd_ram refers to it by scoped names.
package swmd_pkg;

    // Build-time sizes
    localparam int WINDOW_MAX  = 65536;
    localparam int VALUE_BITS  = 20;

    // Fixed field widths of the channels and the length register
    localparam int VAL_W = 20;
    localparam int CFG_W = 17;
    localparam int OUT_W = 17;

    // Derived sizes
    localparam int WIN_AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W       = LEN_W;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;

    // Request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One queued request
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } t_item;

    // Head of the request queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    // Length register value to the window length in use: zero acts as one,
    // anything above the store size is clamped to it.
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] cfg);
        logic [31:0] w;
        w = 32'(cfg);
        if (w == 32'd0) w = 32'd1;
        if (w > 32'(WINDOW_MAX)) w = 32'(WINDOW_MAX);
        return LEN_W'(w);
    endfunction

endpackage

### src/swmd_if.sv
// Valid/ready channel interfaces for input requests and results.
// Depends on swmd_pkg for the payload widths.
interface swmd_in_if;
    logic                       valid;
    logic                       ready;
    logic [swmd_pkg::VAL_W-1:0] value;
    logic                       end_of_sequence;

    modport source (output valid, value, end_of_sequence, input ready);
    modport sink   (input valid, value, end_of_sequence, output ready);
endinterface

interface swmd_out_if;
    logic                       valid;
    logic                       ready;
    logic [swmd_pkg::OUT_W-1:0] min_distinct;
    logic                       short_sequence;

    modport source (output valid, min_distinct, short_sequence, input ready);
    modport sink   (input valid, min_distinct, short_sequence, output ready);
endinterface

### src/swmd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read of the address written in the same cycle returns old data.
module swmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/swmd_front.sv
// Front end: accepts input requests, trims the value to the table index and
// queues them for the back end. Depends on swmd_pkg and swmd_if.
module swmd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    swmd_in_if.sink              i_in,
    input  logic                 i_clr_busy,
    output swmd_pkg::t_q2b       o_q,
    input  logic                 i_pop
);

    swmd_pkg::t_item          r_q_mem [swmd_pkg::QDEPTH];
    logic [swmd_pkg::QAW-1:0] r_wr_ptr;
    logic [swmd_pkg::QAW-1:0] r_rd_ptr;
    logic [swmd_pkg::QAW:0]   r_count;
    logic                     push;
    swmd_pkg::t_item          in_item;

    // Hold off requests while the table clear runs or the queue is full
    assign i_in.ready = (r_count != (swmd_pkg::QAW + 1)'(swmd_pkg::QDEPTH)) && !i_clr_busy;
    assign push       = i_in.valid && i_in.ready;

    // Classify: table index and end-of-sequence marker
    assign in_item.value = swmd_pkg::VALUE_BITS'(i_in.value);
    assign in_item.last  = i_in.end_of_sequence;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr_ptr] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + swmd_pkg::QAW'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + swmd_pkg::QAW'(1);
            case ({push, i_pop})
                2'b10:   r_count <= r_count + (swmd_pkg::QAW + 1)'(1);
                2'b01:   r_count <= r_count - (swmd_pkg::QAW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_q_mem[r_rd_ptr];

endmodule

### src/swmd_back.sv
// Back end: occurrence-table updates, distinct/best tracking, result register
// and the drain after each sequence. Depends on swmd_pkg, swmd_if, swmd_ram.
module swmd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [swmd_pkg::CFG_W-1:0]  i_window_len,
    input  swmd_pkg::t_q2b              i_q,
    output logic                        o_pop,
    output logic                        o_clr_busy,
    swmd_out_if.source                  o_out
);

    localparam int VB  = swmd_pkg::VALUE_BITS;
    localparam int LW  = swmd_pkg::LEN_W;
    localparam int CW  = swmd_pkg::CNT_W;
    localparam int WAW = swmd_pkg::WIN_AW;

    // Sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_OLD        = 3'd1;
    localparam logic [2:0] S_REM        = 3'd2;
    localparam logic [2:0] S_ADD        = 3'd3;
    localparam logic [2:0] S_DRAIN      = 3'd4;
    localparam logic [2:0] S_DRAIN_LAST = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [VB-1:0] r_val, n_val;
    logic          r_last, n_last;
    logic          r_full, n_full;
    logic [VB-1:0] r_old, n_old;
    logic [CW-1:0] r_rem_cnt, n_rem_cnt;
    logic [LW-1:0] r_distinct, n_distinct;
    logic [LW-1:0] r_best, n_best;
    logic [LW-1:0] r_items_seen, n_items_seen;
    logic [WAW-1:0] r_ptr, n_ptr;
    logic [LW-1:0] r_active_len, n_active_len;
    logic [LW-1:0] r_drain_idx, n_drain_idx;
    logic [LW-1:0] r_drain_cnt, n_drain_cnt;
    logic [VB-1:0] r_clr_addr;
    logic          r_clr_busy;
    logic          r_out_valid, n_out_valid;
    logic [swmd_pkg::OUT_W-1:0] r_out_min, n_out_min;
    logic          r_out_short, n_out_short;

    // Memory ports
    logic           occ_we;
    logic [VB-1:0]  occ_waddr;
    logic [CW-1:0]  occ_wdata;
    logic [VB-1:0]  occ_raddr;
    logic [CW-1:0]  occ_rdata;
    logic           ws_we;
    logic [WAW-1:0] ws_waddr;
    logic [VB-1:0]  ws_wdata;
    logic [WAW-1:0] ws_raddr;
    logic [VB-1:0]  ws_rdata;

    // Scratch values of the sequencer
    logic           first;
    logic [LW-1:0]  len;
    logic [WAW-1:0] ptr;
    logic [CW-1:0]  cnt;
    logic [LW-1:0]  dist_new;
    logic [LW-1:0]  best_new;
    logic [LW-1:0]  items_new;
    logic           full_after;
    logic           slot_free;

    swmd_ram #(.WIDTH(CW), .DEPTH(swmd_pkg::TABLE_DEPTH)) u_occ (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    swmd_ram #(.WIDTH(VB), .DEPTH(swmd_pkg::WINDOW_MAX)) u_win (
        .i_clk   (i_clk),
        .i_we    (ws_we),
        .i_waddr (ws_waddr),
        .i_wdata (ws_wdata),
        .i_raddr (ws_raddr),
        .o_rdata (ws_rdata)
    );

    assign slot_free = !r_out_valid || o_out.ready;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_last       = r_last;
        n_full       = r_full;
        n_old        = r_old;
        n_rem_cnt    = r_rem_cnt;
        n_distinct   = r_distinct;
        n_best       = r_best;
        n_items_seen = r_items_seen;
        n_ptr        = r_ptr;
        n_active_len = r_active_len;
        n_drain_idx  = r_drain_idx;
        n_drain_cnt  = r_drain_cnt;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_min    = r_out_min;
        n_out_short  = r_out_short;
        o_pop        = 1'b0;
        occ_we       = 1'b0;
        occ_waddr    = r_old;
        occ_wdata    = '0;
        occ_raddr    = r_val;
        ws_we        = 1'b0;
        ws_waddr     = r_ptr;
        ws_wdata     = i_q.item.value;
        ws_raddr     = r_ptr;
        first        = (r_items_seen == '0);
        len          = first ? swmd_pkg::eff_len(i_window_len) : r_active_len;
        ptr          = first ? '0 : r_ptr;
        cnt          = (r_full && (r_val == r_old)) ? r_rem_cnt : occ_rdata;
        dist_new     = r_distinct + LW'(cnt == '0);
        items_new    = r_full ? r_items_seen : r_items_seen + LW'(1);
        best_new     = r_best;
        if (r_full) begin
            if (dist_new < r_best) best_new = dist_new;
        end else if (items_new == r_active_len) begin
            best_new = dist_new;
        end
        full_after   = (items_new >= r_active_len);

        case (r_state)
            S_IDLE: begin
                // Take the next request; store its value in the delay line
                occ_raddr = i_q.item.value;
                ws_raddr  = ptr;
                ws_waddr  = ptr;
                if (i_q.valid && !r_clr_busy) begin
                    o_pop        = 1'b1;
                    ws_we        = 1'b1;
                    n_val        = i_q.item.value;
                    n_last       = i_q.item.last;
                    n_full       = (r_items_seen >= len);
                    n_active_len = len;
                    n_ptr        = ((LW'(ptr) + LW'(1)) == len) ? '0 : ptr + WAW'(1);
                    n_state      = (r_items_seen >= len) ? S_OLD : S_ADD;
                end
            end
            S_OLD: begin
                // Leaving value is out of the delay line: look up its count
                n_old     = ws_rdata;
                occ_raddr = ws_rdata;
                n_state   = S_REM;
            end
            S_REM: begin
                // Remove the leaving value; fetch the entering one meanwhile
                occ_waddr = r_old;
                occ_wdata = occ_rdata - CW'(1);
                n_rem_cnt = occ_rdata;
                if (occ_rdata != '0) begin
                    occ_we    = 1'b1;
                    n_rem_cnt = occ_rdata - CW'(1);
                    if (occ_rdata == CW'(1) && r_distinct != '0) begin
                        n_distinct = r_distinct - LW'(1);
                    end
                end
                occ_raddr = r_val;
                n_state   = S_ADD;
            end
            S_ADD: begin
                // Count the entering value; end of sequence waits for the result slot
                if (!r_last || slot_free) begin
                    occ_we       = 1'b1;
                    occ_waddr    = r_val;
                    occ_wdata    = cnt + CW'(1);
                    n_distinct   = dist_new;
                    n_best       = best_new;
                    n_items_seen = items_new;
                    n_state      = S_IDLE;
                    if (r_last) begin
                        n_out_valid  = 1'b1;
                        n_out_min    = swmd_pkg::OUT_W'(full_after ? best_new : dist_new);
                        n_out_short  = !full_after;
                        n_drain_cnt  = items_new;
                        n_drain_idx  = '0;
                        n_distinct   = '0;
                        n_best       = '0;
                        n_items_seen = '0;
                        n_ptr        = '0;
                        n_state      = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // One delay-line slot per cycle; its table entry goes to zero
                ws_raddr    = r_drain_idx[WAW-1:0];
                occ_waddr   = ws_rdata;
                occ_wdata   = '0;
                occ_we      = (r_drain_idx != '0);
                n_drain_idx = r_drain_idx + LW'(1);
                if ((r_drain_idx + LW'(1)) == r_drain_cnt) n_state = S_DRAIN_LAST;
            end
            S_DRAIN_LAST: begin
                occ_waddr = ws_rdata;
                occ_wdata = '0;
                occ_we    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Table clear after reset takes the write port
        if (r_clr_busy) begin
            occ_we    = 1'b1;
            occ_waddr = r_clr_addr;
            occ_wdata = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_distinct   <= '0;
            r_best       <= '0;
            r_items_seen <= '0;
            r_ptr        <= '0;
            r_active_len <= LW'(1);
            r_drain_idx  <= '0;
            r_drain_cnt  <= '0;
            r_out_valid  <= 1'b0;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_state      <= n_state;
            r_distinct   <= n_distinct;
            r_best       <= n_best;
            r_items_seen <= n_items_seen;
            r_ptr        <= n_ptr;
            r_active_len <= n_active_len;
            r_drain_idx  <= n_drain_idx;
            r_drain_cnt  <= n_drain_cnt;
            r_out_valid  <= n_out_valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + VB'(1);
                if (&r_clr_addr) r_clr_busy <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_last      <= n_last;
        r_full      <= n_full;
        r_old       <= n_old;
        r_rem_cnt   <= n_rem_cnt;
        r_out_min   <= n_out_min;
        r_out_short <= n_out_short;
    end

    assign o_clr_busy           = r_clr_busy;
    assign o_out.valid          = r_out_valid;
    assign o_out.min_distinct   = r_out_min;
    assign o_out.short_sequence = r_out_short;

    // Window never holds more distinct values than items
    a_distinct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct <= r_items_seen)
        else $error("distinct count above items in window");

    // Item count saturates at the latched length
    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items_seen <= r_active_len)
        else $error("items seen beyond window length");

    // No request taken while the table is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == S_IDLE) && !o_pop)
        else $error("request taken during table clear");

    // Drain index stays inside the filled part of the delay line
    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_drain_idx < r_drain_cnt))
        else $error("drain index out of range");

    // A result is loaded only into a free result slot
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_last && !slot_free) |=> (r_state == S_ADD))
        else $error("result slot overrun");

endmodule

### src/sliding_window_min_distinct.sv
// Top level of the sliding-window minimum distinct counter: length register,
// front end with request queue, back end. Depends on swmd_pkg, swmd_if and the modules.
//
// Usage:
//   i_in carries one value per request; end_of_sequence marks the last one.
//   o_out carries one result per sequence: the least distinct count over all
//   full windows, or the count over all values with short_sequence set when
//   the sequence was shorter than the window.
//   i_cfg_we/i_cfg_data write the window length (0 acts as 1, above the
//   delay-line size it is clamped); it takes effect with the next sequence.
// Sequencing: a request passes S_IDLE and S_ADD while the window fills and
//   S_IDLE, S_OLD, S_REM, S_ADD once it is full (two table read-modify-writes
//   through one table port); the next request is taken only back in S_IDLE. After the
//   last request the back end clears the window from the table in S_DRAIN and
//   S_DRAIN_LAST, while the queue keeps taking requests until it is full.
// Reset: synchronous, active low. Afterwards all 2^20 entries of the occurrence
//   table are cleared with i_in.ready low; config writes are taken meanwhile.
// Stall: a held result blocks only the next end-of-sequence request; the
//   queue of 4 requests fills and then i_in.ready drops.
module sliding_window_min_distinct (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swmd_in_if.sink                     i_in,
    swmd_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [swmd_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [swmd_pkg::CFG_W-1:0] r_window_len;
    swmd_pkg::t_q2b             q;
    logic                       pop;
    logic                       clr_busy;

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swmd_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_window_len <= i_cfg_data;
        end
    end

    swmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_clr_busy (clr_busy),
        .o_q        (q),
        .i_pop      (pop)
    );

    swmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_len (r_window_len),
        .i_q          (q),
        .o_pop        (pop),
        .o_clr_busy   (clr_busy),
        .o_out        (o_out)
    );

endmodule
